/* rtl/core/sbmh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmh_pkg
// Shared constants for the salted byte-mix hash: seed, round constants,
// field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package sbmh_pkg;

  localparam int unsigned SALT_BYTES_DEF = 8;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_ADDR_W = 1;

  localparam logic [HASH_W-1:0] SEED_VALUE = 32'hDEADBEEF;
  localparam logic [HASH_W-1:0] XOR_CONST  = 32'hADEF8593;
  localparam logic [HASH_W-1:0] MUL_CONST  = 32'h34FE9B09;

  localparam logic [CFG_ADDR_W-1:0] REG_SALT_WORD   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_SALT_LENGTH = 1'b1;

endpackage

/* rtl/core/sbmh_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmh interfaces
// Valid/ready channels for message bytes in and hash values out.
// ----------------------------------------------------------------------------
interface sbmh_in_if import sbmh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] message_byte;
  logic              last_byte;

  modport source (output valid, output message_byte, output last_byte, input ready);
  modport sink   (input valid, input message_byte, input last_byte, output ready);
endinterface

interface sbmh_out_if import sbmh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

/* rtl/core/salted_byte_mix_hash32_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salted_byte_mix_hash32_top
// Salted 32-bit byte-mix hash. A small sequencer drives one shared mixing
// round twice per message byte: message byte first, then salt byte.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  in_req   | in  | valid / ready    | message_byte[7:0], last_byte
//  out_res  | out | valid / ready    | hash_value[31:0]
//  cfg      | in  | cfg_we           | cfg_addr[0], cfg_wdata[63:0]
//
//  one request steps in turn through accept, message round, salt round
//  the multiplier in the mixing round sets the round time, one round a cycle unless a last byte's salt round stalls
//  the hash sits in an output register; a new request is taken while it waits
//  a last byte stalls in its salt round only while an earlier hash is unread
//  reset (rst_n, synchronous) sets the seed, salt position 0 and length 8
// ----------------------------------------------------------------------------
module salted_byte_mix_hash32_top import sbmh_pkg::*; #(
  parameter int unsigned SALT_BYTES = SALT_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sbmh_in_if.sink               in_req,
  sbmh_out_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int unsigned POS_W  = (SALT_BYTES > 1) ? $clog2(SALT_BYTES) : 1;
  localparam int unsigned SALT_W = SALT_BYTES * BYTE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MSG  = 2'd1;
  localparam logic [1:0] ST_SALT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [HASH_W-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  logic [SALT_W-1:0] salt_word_r;
  logic [LEN_W-1:0]  salt_length_r;
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] out_hash_r;
  logic              out_load;

  logic [BYTE_W-1:0] round_byte;
  logic [HASH_W-1:0] round_acc;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  pos_inc;

  sbmh_mix_round u_round (
    .acc_in  (acc_r),
    .byte_in (round_byte),
    .acc_out (round_acc)
  );

  assign in_req.ready       = (state_r == ST_IDLE);
  assign out_res.valid      = out_valid_r;
  assign out_res.hash_value = out_hash_r;

  // salt length clamp
  always_comb begin
    eff_len = salt_length_r;
    if (eff_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (eff_len > LEN_W'(SALT_BYTES)) begin
      eff_len = LEN_W'(SALT_BYTES);
    end
    pos_inc = LEN_W'(pos_r) + LEN_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_res.ready;
    round_byte    = byte_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = ST_MSG;
        end
      end
      ST_MSG: begin
        acc_nxt   = round_acc;
        state_nxt = ST_SALT;
      end
      ST_SALT: begin
        round_byte = salt_word_r[pos_r*BYTE_W +: BYTE_W];
        if (!last_r) begin
          acc_nxt   = round_acc;
          pos_nxt   = (pos_inc >= eff_len) ? '0 : POS_W'(pos_inc);
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_res.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          acc_nxt       = SEED_VALUE;
          pos_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      acc_r         <= SEED_VALUE;
      pos_r         <= '0;
      out_valid_r   <= 1'b0;
      salt_word_r   <= '0;
      salt_length_r <= LEN_W'(8);
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SALT_WORD:   salt_word_r   <= cfg_wdata[SALT_W-1:0];
          REG_SALT_LENGTH: salt_length_r <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      byte_r <= in_req.message_byte;
      last_r <= in_req.last_byte;
    end
    if (out_load) begin
      out_hash_r <= round_acc;
    end
  end

endmodule

/* rtl/core/sbmh_mix_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmh_mix_round
// One mixing round: sign xor, constant xor, constant multiply, shifted xor,
// rotate left by 8 and a final xor of the sign-extended byte.
// ----------------------------------------------------------------------------
module sbmh_mix_round import sbmh_pkg::*; (
  input  logic [HASH_W-1:0] acc_in,
  input  logic [BYTE_W-1:0] byte_in,
  output logic [HASH_W-1:0] acc_out
);

  logic [HASH_W-1:0] sext;
  logic [HASH_W-1:0] pre;
  logic [HASH_W-1:0] prod;
  logic [HASH_W-1:0] shx;

  always_comb begin
    sext    = {{(HASH_W-BYTE_W){byte_in[BYTE_W-1]}}, byte_in};
    pre     = acc_in ^ {HASH_W{byte_in[BYTE_W-1]}} ^ XOR_CONST;
    prod    = pre * MUL_CONST;
    shx     = prod ^ {sext[HASH_W-14:0], 13'b0};
    acc_out = {shx[HASH_W-9:0], shx[HASH_W-1:HASH_W-8]} ^ sext;
  end

endmodule

/* rtl/core/sbmh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmh_checker
// Port-level checks on the hash block, bound to the top level.
// ----------------------------------------------------------------------------
module sbmh_checker import sbmh_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HASH_W-1:0] hash_value
);

  // request busy for both mixing rounds
  a_busy_two_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("input ready during mixing rounds");

  // a hash only appears at the end of a salt round
  a_hash_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("hash raised without a finished round");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("hash dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(hash_value))
    else $error("hash changed while stalled");

endmodule

bind salted_byte_mix_hash32_top sbmh_checker u_sbmh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .hash_value (out_res.hash_value)
);

/* verif/tb_salted_byte_mix_hash32_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_salted_byte_mix_hash32_top
// Self-checking bench for the salted byte-mix hash. A directed table covers
// byte extremes, salt length clamping, salt wrap and a length change part way
// through a message; random messages follow under random salt settings.
// Every hash is compared with a bit-exact predictor kept in step with each
// accepted request. Both channels see random gaps and calm stretches.
// ----------------------------------------------------------------------------
module tb_salted_byte_mix_hash32_top;
  import sbmh_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_BYTES  = 1200;
  localparam int unsigned NUM_DIR       = 29;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_W-1:0]      data;
    logic [BYTE_W-1:0]     msg;
    logic                  last;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;

  sbmh_in_if  in_ch ();
  sbmh_out_if out_ch ();

  salted_byte_mix_hash32_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [HASH_W-1:0] acc_model;
  int unsigned       salt_pos_model;
  logic [CFG_W-1:0]  salt_word_model;
  logic [LEN_W-1:0]  salt_len_model;

  logic [HASH_W-1:0] hash_q [$];
  logic [HASH_W-1:0] exp_hash;
  int unsigned       err_cnt = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       bytes_sent = 0;
  bit                no_idle = 1'b0;

  always #10 clk = ~clk;

  function automatic logic [HASH_W-1:0] mix_round(input logic [HASH_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] s;
    s   = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    acc = acc ^ {HASH_W{b[BYTE_W-1]}};
    acc = acc ^ XOR_CONST;
    acc = acc * MUL_CONST;
    acc = acc ^ (s << 13);
    acc = {acc[HASH_W-9:0], acc[HASH_W-1:HASH_W-8]};
    acc = acc ^ s;
    return acc;
  endfunction

  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic l);
    logic [BYTE_W-1:0] salt_b;
    int unsigned       len;
    salt_b = salt_word_model[salt_pos_model*8 +: 8];
    len = 32'(salt_len_model);
    if (len == 0) len = 1;
    if (len > SALT_BYTES_DEF) len = SALT_BYTES_DEF;
    acc_model = mix_round(mix_round(acc_model, b), salt_b);
    salt_pos_model = (salt_pos_model + 1 >= len) ? 0 : salt_pos_model + 1;
    if (l) begin
      hash_q.push_back(acc_model);
      acc_model = SEED_VALUE;
      salt_pos_model = 0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stim_row_t byte_row(input logic [BYTE_W-1:0] m, input logic l);
    stim_row_t r;
    r.kind = ROW_BYTE;
    r.addr = '0;
    r.data = '0;
    r.msg  = m;
    r.last = l;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_ADDR_W-1:0] a,
                                        input logic [CFG_W-1:0] d);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.addr = a;
    r.data = d;
    r.msg  = '0;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t directed_row(input int idx);
    case (idx)
      0:  return byte_row(8'h00, 1'b1);
      1:  return byte_row(8'hFF, 1'b1);
      2:  return byte_row(8'h80, 1'b0);
      3:  return byte_row(8'h7F, 1'b1);
      4:  return cfg_row(REG_SALT_WORD, 64'hFFFF_FFFF_FFFF_FFFF);
      5:  return cfg_row(REG_SALT_LENGTH, 64'd1);
      6:  return byte_row(8'h01, 1'b0);
      7:  return byte_row(8'h80, 1'b1);
      8:  return cfg_row(REG_SALT_WORD, 64'h8877_6655_4433_2211);
      // zero length behaves as one
      9:  return cfg_row(REG_SALT_LENGTH, 64'd0);
      10: return byte_row(8'hA5, 1'b0);
      11: return byte_row(8'h5A, 1'b1);
      // oversized length saturates, nine bytes wrap the salt
      12: return cfg_row(REG_SALT_LENGTH, 64'hF);
      13: return byte_row(8'h11, 1'b0);
      14: return byte_row(8'h22, 1'b0);
      15: return byte_row(8'h33, 1'b0);
      16: return byte_row(8'h44, 1'b0);
      17: return byte_row(8'h55, 1'b0);
      18: return byte_row(8'h66, 1'b0);
      19: return byte_row(8'h77, 1'b0);
      20: return byte_row(8'h88, 1'b0);
      21: return byte_row(8'h99, 1'b1);
      22: return cfg_row(REG_SALT_LENGTH, 64'd8);
      23: return byte_row(8'hC3, 1'b0);
      24: return byte_row(8'h3C, 1'b0);
      25: return byte_row(8'hE1, 1'b0);
      // length lowered below the current position mid-message
      26: return cfg_row(REG_SALT_LENGTH, 64'd2);
      27: return byte_row(8'h1E, 1'b0);
      default: return byte_row(8'hFF, 1'b1);
    endcase
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic l);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_byte <= b;
    in_ch.last_byte    <= l;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_byte(b, l);
    bytes_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (a == REG_SALT_WORD) salt_word_model = d;
    else if (a == REG_SALT_LENGTH) salt_len_model = d[LEN_W-1:0];
  endtask

  task automatic shuffle_config();
    logic [CFG_W-1:0] w;
    int unsigned      sel;
    sel = $urandom_range(0, 3);
    if (sel != 3) begin
      case ($urandom_range(0, 5))
        0: w = '0;
        1: w = '1;
        default: w = {$urandom, $urandom};
      endcase
      write_reg(REG_SALT_WORD, w);
    end
    if (sel != 2) begin
      w = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0: w[LEN_W-1:0] = 4'd1;
        1: w[LEN_W-1:0] = 4'd8;
        2: w[LEN_W-1:0] = 4'd0;
        3: w[LEN_W-1:0] = 4'hF;
        default: w[LEN_W-1:0] = LEN_W'($urandom_range(0, 15));
      endcase
      write_reg(REG_SALT_LENGTH, w);
    end
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 15))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_msg_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 4);
    if (r < 18) return $urandom_range(5, 16);
    return $urandom_range(17, 40);
  endfunction

  // result sink with random back-pressure
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (hash_q.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time,
                 out_ch.hash_value);
        err_cnt++;
      end else begin
        exp_hash = hash_q.pop_front();
        if (out_ch.hash_value !== exp_hash) begin
          $display("%0t: hash_value mismatch, expected %h, actual %h", $time,
                   exp_hash, out_ch.hash_value);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d hashes outstanding", $time, hash_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    int unsigned n_msgs;
    int unsigned len;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.message_byte = '0;
    in_ch.last_byte    = 1'b0;
    acc_model          = SEED_VALUE;
    salt_pos_model     = 0;
    salt_word_model    = '0;
    salt_len_model     = 4'd8;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int idx = 0; idx < NUM_DIR; idx++) begin
      row = directed_row(idx);
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.addr, row.data);
      end else begin
        push_byte(row.msg, row.last);
      end
    end

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      settle();
      no_idle = ($urandom_range(0, 4) == 0);
      shuffle_config();
      n_msgs = $urandom_range(1, 8);
      for (int m = 0; m < n_msgs; m++) begin
        len = pick_msg_len();
        for (int k = 0; k < len; k++) push_byte(pick_byte(), k == len - 1);
      end
      // leave a message open across the next settings change
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 5)) push_byte(pick_byte(), 1'b0);
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
